// File: rtl/core/srlm_pkg.sv
// Shared types and constants of the stereo RMS level meter core.
// Holds the sequencer state type, datapath widths and register indexes.
// No dependencies.
package srlm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 42;
    localparam int COUNT_W   = 13;
    localparam int ACC_W     = 32;
    localparam int LEVEL_W   = 16;
    localparam int SCALED_W  = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W     = SUM_W + 1;
    localparam int DIVISOR_W = 16;
    localparam int STEP_W    = 6;
    localparam int ROOT_W    = 16;
    localparam int SREM_W    = 20;
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int PSUM_W    = 50;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULLSCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    localparam logic [15:0] ALPHA_RST     = 16'd4588;
    localparam logic [15:0] FULLSCALE_RST = 16'd1966;
    localparam logic [16:0] THRESHOLD_RST = 17'd52429;

    localparam logic [SCALED_W-1:0] SCALED_ONE = 17'h10000;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_SQ_L    = 9'b000000010,
        ST_SQ_R    = 9'b000000100,
        ST_DIV_MS  = 9'b000001000,
        ST_ROOT    = 9'b000010000,
        ST_MUL_OLD = 9'b000100000,
        ST_MUL_NEW = 9'b001000000,
        ST_DIV_SC  = 9'b010000000,
        ST_FINISH  = 9'b100000000
    } state_t;

endpackage

// File: rtl/core/stereo_rms_level_meter_core.sv
// Stereo RMS level meter core: frame accumulator, shared divider, root unit
// and smoothing multiplier under one sequencer.
// Depends on srlm_pkg.
//
// Usage:
//   s_* channel carries one stereo frame per transfer: s_tdata holds the left
//   sample in bits 15:0 and the right sample in bits 31:16 (signed Q1.15);
//   s_tlast marks the final frame of a buffer. A buffer also closes when it
//   reaches MAX_FRAMES frames.
//   m_* channel carries one result per closed buffer: smoothed level (Q0.16),
//   scaled level min(1, level/full_scale) (Q1.16) and the loud flag in m_tuser.
//   cfg_* writes alpha, full scale and loud threshold; write only while idle.
// Sequencing:
//   A frame that does not close a buffer goes through the transfer and then
//   two passes through the shared 17x32 multiplier, one per channel.
//   A closing frame runs the squaring of both channels, 43 steps of the
//   bit-serial divider for the mean square, 16 root steps, 2 multiplier
//   passes for the smoothing, 43 more divider steps for the scaled level and
//   a final state that loads the output register.
// Reset clears the running sum, frame count and smoothed level and restores
// the register defaults. A result waits in the output register while the
// receiver stalls; the core keeps taking frames meanwhile and holds only when
// the next result is done and the output register is still full.
module stereo_rms_level_meter_core #(
    parameter int MAX_FRAMES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] left_sample, [31:16] right_sample
    input  logic        s_tlast,    // last_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [15:0] smoothed_level, [32:16] scaled_level, zero pad
    output logic        m_tuser,    // loud
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);

    localparam logic [srlm_pkg::COUNT_W-1:0] FRAME_LIMIT = srlm_pkg::COUNT_W'(MAX_FRAMES);
    localparam logic [srlm_pkg::STEP_W-1:0] DIV_LAST  = srlm_pkg::STEP_W'(srlm_pkg::DIV_W - 1);
    localparam logic [srlm_pkg::STEP_W-1:0] ROOT_LAST = srlm_pkg::STEP_W'(srlm_pkg::ROOT_W - 1);

    srlm_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic [15:0] alpha_reg;
    logic [15:0] fullscale_reg;
    logic [16:0] threshold_reg;

    // Captured frame
    logic [srlm_pkg::SAMPLE_W-1:0] left_reg, left_next;
    logic [srlm_pkg::SAMPLE_W-1:0] right_reg, right_next;
    logic                          last_reg, last_next;

    // Architectural state
    logic [srlm_pkg::SUM_W-1:0]   square_sum_reg, square_sum_next;
    logic [srlm_pkg::COUNT_W-1:0] frame_count_reg, frame_count_next;
    logic [srlm_pkg::ACC_W-1:0]   acc_reg, acc_next;

    // Divider and root unit
    logic [srlm_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [srlm_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [srlm_pkg::DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [srlm_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [srlm_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [srlm_pkg::SREM_W-1:0]    srem_reg, srem_next;
    logic [srlm_pkg::PSUM_W-1:0]    psum_reg, psum_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [srlm_pkg::LEVEL_W-1:0]   out_level_reg, out_level_next;
    logic [srlm_pkg::SCALED_W-1:0]  out_scaled_reg, out_scaled_next;
    logic                           out_loud_reg, out_loud_next;

    // Shared multiplier
    logic [srlm_pkg::MUL_A_W-1:0] mul_a;
    logic [srlm_pkg::MUL_B_W-1:0] mul_b;
    logic [srlm_pkg::MUL_P_W-1:0] mul_p;

    logic signed [srlm_pkg::SAMPLE_W-1:0] half_left, half_right;
    logic [srlm_pkg::SAMPLE_W-1:0] mag_left, mag_right;

    logic [srlm_pkg::DIVISOR_W:0]   div_trial, div_diff;
    logic                           div_ge;
    logic [srlm_pkg::SREM_W-1:0]    sq_shift, sq_trial;
    logic                           sq_ge;

    logic [srlm_pkg::SUM_W-1:0]     sum_total;
    logic [srlm_pkg::COUNT_W-1:0]   count_total;
    logic [srlm_pkg::PSUM_W-1:0]    smooth_total;
    logic [srlm_pkg::SCALED_W-1:0]  scaled_sat;
    logic                           out_free;

    // Halve each sample with floor, then take the magnitude for squaring
    assign half_left  = $signed(left_reg) >>> 1;
    assign half_right = $signed(right_reg) >>> 1;
    assign mag_left   = half_left[15]  ? 16'(-half_left)  : 16'(half_left);
    assign mag_right  = half_right[15] ? 16'(-half_right) : 16'(half_right);

    // Operand select for the one multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            srlm_pkg::ST_SQ_L:
            begin
                mul_a = {1'b0, mag_left};
                mul_b = {16'd0, mag_left};
            end
            srlm_pkg::ST_SQ_R:
            begin
                mul_a = {1'b0, mag_right};
                mul_b = {16'd0, mag_right};
            end
            srlm_pkg::ST_MUL_OLD:
            begin
                mul_a = 17'h10000 - {1'b0, alpha_reg};
                mul_b = acc_reg;
            end
            srlm_pkg::ST_MUL_NEW:
            begin
                mul_a = {1'b0, alpha_reg};
                mul_b = {16'd0, root_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Restoring divide step: one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[srlm_pkg::DIV_W-1]};
    assign div_diff  = div_trial - {1'b0, divisor_reg};
    assign div_ge    = div_trial >= {1'b0, divisor_reg};

    // Digit-by-digit root step: two radicand bits per cycle
    assign sq_shift = {srem_reg[srlm_pkg::SREM_W-3:0], quo_reg[31:30]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_shift >= sq_trial;

    assign sum_total    = square_sum_reg + mul_p[srlm_pkg::SUM_W-1:0];
    assign count_total  = frame_count_reg + 13'd1;
    assign smooth_total = psum_reg + {mul_p[33:0], 16'd0};
    assign scaled_sat   = (quo_reg > 43'd65536) ? srlm_pkg::SCALED_ONE
                                                : quo_reg[srlm_pkg::SCALED_W-1:0];
    assign out_free     = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next       = state_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        last_next        = last_reg;
        square_sum_next  = square_sum_reg;
        frame_count_next = frame_count_reg;
        acc_next         = acc_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        divisor_next     = divisor_reg;
        step_next        = step_reg;
        root_next        = root_reg;
        srem_next        = srem_reg;
        psum_next        = psum_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_level_next   = out_level_reg;
        out_scaled_next  = out_scaled_reg;
        out_loud_next    = out_loud_reg;

        case (state_reg)
            srlm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    left_next  = s_tdata[15:0];
                    right_next = s_tdata[31:16];
                    last_next  = s_tlast;
                    state_next = srlm_pkg::ST_SQ_L;
                end
            end
            srlm_pkg::ST_SQ_L:
            begin
                square_sum_next = sum_total;
                state_next      = srlm_pkg::ST_SQ_R;
            end
            srlm_pkg::ST_SQ_R:
            begin
                if (last_reg || count_total >= FRAME_LIMIT)
                begin
                    // Close the buffer: divide 2*sum by the frame count
                    quo_next         = {sum_total, 1'b0};
                    divisor_next     = 16'(count_total);
                    rem_next         = '0;
                    step_next        = DIV_LAST;
                    square_sum_next  = '0;
                    frame_count_next = '0;
                    state_next       = srlm_pkg::ST_DIV_MS;
                end
                else
                begin
                    square_sum_next  = sum_total;
                    frame_count_next = count_total;
                    state_next       = srlm_pkg::ST_IDLE;
                end
            end
            srlm_pkg::ST_DIV_MS, srlm_pkg::ST_DIV_SC:
            begin
                rem_next  = div_ge ? div_diff[srlm_pkg::DIVISOR_W-1:0]
                                   : div_trial[srlm_pkg::DIVISOR_W-1:0];
                quo_next  = {quo_reg[srlm_pkg::DIV_W-2:0], div_ge};
                step_next = step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    if (state_reg == srlm_pkg::ST_DIV_MS)
                    begin
                        root_next  = '0;
                        srem_next  = '0;
                        step_next  = ROOT_LAST;
                        state_next = srlm_pkg::ST_ROOT;
                    end
                    else
                    begin
                        state_next = srlm_pkg::ST_FINISH;
                    end
                end
            end
            srlm_pkg::ST_ROOT:
            begin
                srem_next = sq_ge ? (sq_shift - sq_trial) : sq_shift;
                root_next = {root_reg[srlm_pkg::ROOT_W-2:0], sq_ge};
                quo_next  = {quo_reg[srlm_pkg::DIV_W-3:0], 2'b00};
                step_next = step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    state_next = srlm_pkg::ST_MUL_OLD;
                end
            end
            srlm_pkg::ST_MUL_OLD:
            begin
                psum_next  = srlm_pkg::PSUM_W'(mul_p);
                state_next = srlm_pkg::ST_MUL_NEW;
            end
            srlm_pkg::ST_MUL_NEW:
            begin
                // Fold in the new RMS, then divide level<<16 by full scale
                acc_next     = smooth_total[47:16];
                quo_next     = {11'd0, smooth_total[47:32], 16'd0};
                divisor_next = (fullscale_reg == '0) ? 16'd1 : fullscale_reg;
                rem_next     = '0;
                step_next    = DIV_LAST;
                state_next   = srlm_pkg::ST_DIV_SC;
            end
            srlm_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_level_next  = acc_reg[31:16];
                    out_scaled_next = scaled_sat;
                    out_loud_next   = scaled_sat > threshold_reg;
                    state_next      = srlm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= srlm_pkg::ST_IDLE;
            alpha_reg       <= srlm_pkg::ALPHA_RST;
            fullscale_reg   <= srlm_pkg::FULLSCALE_RST;
            threshold_reg   <= srlm_pkg::THRESHOLD_RST;
            square_sum_reg  <= '0;
            frame_count_reg <= '0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            square_sum_reg  <= square_sum_next;
            frame_count_reg <= frame_count_next;
            acc_reg         <= acc_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    srlm_pkg::REG_ALPHA:     alpha_reg     <= cfg_wdata[15:0];
                    srlm_pkg::REG_FULLSCALE: fullscale_reg <= cfg_wdata[15:0];
                    srlm_pkg::REG_THRESHOLD: threshold_reg <= cfg_wdata;
                    default:                 ;
                endcase
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        left_reg       <= left_next;
        right_reg      <= right_next;
        last_reg       <= last_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        step_reg       <= step_next;
        root_reg       <= root_next;
        srem_reg       <= srem_next;
        psum_reg       <= psum_next;
        out_level_reg  <= out_level_next;
        out_scaled_reg <= out_scaled_next;
        out_loud_reg   <= out_loud_next;
    end

    assign s_tready = (state_reg == srlm_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_scaled_reg, out_level_reg};
    assign m_tuser  = out_loud_reg;

`ifndef SYNTHESIS
    // Frame count never reaches the buffer limit between frames
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg < FRAME_LIMIT)
        else $error("frame count reached buffer limit");

    // Scaled level saturates at one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:16] <= srlm_pkg::SCALED_ONE))
        else $error("scaled level above one");

    // Smoothed accumulator stays within the RMS range
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= 32'h8000_0000)
        else $error("smoothed level out of range");

    // A finished result is never dropped while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srlm_pkg::ST_FINISH && out_valid_reg && !m_tready)
        |=> (state_reg == srlm_pkg::ST_FINISH))
        else $error("result left the sequencer while output was full");
`endif

endmodule
